>>> src/assert_macros.svh
// Assertion macros for the RTL files that carry checks (imap_keyword_classifier).
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Implication in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> src/ikc_pkg.sv
// Package for the IMAP keyword classifier: keyword table, widths,
// verdict codes and the per-byte keyword hit function. No dependencies.
package ikc_pkg;

    localparam int WIN_DEPTH = 9;
    localparam int KW_COUNT  = 13;
    localparam int KW_MAX    = 10;
    localparam int KW_BITS   = KW_MAX * 8;
    localparam int VERDICT_W = 4;

    localparam logic [VERDICT_W-1:0] VERDICT_NOOP    = 4'd6;
    localparam logic [VERDICT_W-1:0] VERDICT_UNKNOWN = 4'd13;

    // Last character of each keyword sits in the low byte.
    localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
        KW_BITS'("OK LOGIN"),
        KW_BITS'("LOGIN"),
        KW_BITS'("SELECT"),
        KW_BITS'("NO"),
        KW_BITS'("BYE LOGOUT"),
        KW_BITS'("LOGOUT"),
        KW_BITS'("NOOP"),
        KW_BITS'("LIST"),
        KW_BITS'("CREATE"),
        KW_BITS'("DELETE"),
        KW_BITS'("RENAME"),
        KW_BITS'("SEARCH ALL"),
        KW_BITS'("OK")
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd8, 4'd5, 4'd6, 4'd2, 4'd10, 4'd6, 4'd4, 4'd4, 4'd6, 4'd6, 4'd6, 4'd10, 4'd2
    };

    // Index 0 is the oldest byte, the top index the newest.
    typedef logic [WIN_DEPTH-1:0][7:0] t_window;

    typedef struct packed {
        logic       fire;
        logic       last;
        logic [7:0] data;
    } t_step;

    // Keywords that end at byte b, given the bytes before it.
    function automatic logic [KW_COUNT-1:0] kw_hits(t_window w, logic [7:0] b);
        logic [KW_MAX-1:0][7:0] back;
        logic [KW_COUNT-1:0]    hits;
        back[0] = b;
        for (int i = 1; i < KW_MAX; i++) begin
            back[i] = w[WIN_DEPTH-i];
        end
        for (int k = 0; k < KW_COUNT; k++) begin
            hits[k] = 1'b1;
            for (int i = 0; i < KW_MAX; i++) begin
                if ((i < int'(KW_LEN[k])) && (back[i] != KW_TEXT[k][i*8 +: 8])) begin
                    hits[k] = 1'b0;
                end
            end
        end
        return hits;
    endfunction

endpackage

>>> src/ikc_match.sv
// Byte window, sticky seen flags and end-of-text flag of the classifier.
// Depends on ikc_pkg for the keyword table and the step struct.
module ikc_match import ikc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_step               i_step,
    output logic [KW_COUNT-1:0] o_seen_next
);

    t_window             r_window, n_window;
    logic [KW_COUNT-1:0] r_seen, n_seen;
    logic                r_ended, n_ended;
    logic [KW_COUNT-1:0] hits;
    logic                take;

    assign hits = kw_hits(r_window, i_step.data);
    assign take = i_step.fire && !r_ended && (i_step.data != 8'd0);

    assign o_seen_next = take ? (r_seen | hits) : r_seen;

    always_comb begin
        n_window = r_window;
        n_seen   = r_seen;
        n_ended  = r_ended;
        if (i_step.fire) begin
            if (i_step.last) begin
                // packet done: start over
                n_window = '0;
                n_seen   = '0;
                n_ended  = 1'b0;
            end else if (!r_ended) begin
                if (i_step.data == 8'd0) begin
                    n_ended = 1'b1;
                end else begin
                    n_window = {i_step.data, r_window[WIN_DEPTH-1:1]};
                    n_seen   = r_seen | hits;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_seen   <= '0;
            r_ended  <= 1'b0;
        end else begin
            r_window <= n_window;
            r_seen   <= n_seen;
            r_ended  <= n_ended;
        end
    end

endmodule

>>> src/ikc_prio.sv
// Priority encoder from seen flags to verdict code.
// Depends on ikc_pkg for the keyword count and the UNKNOWN code.
module ikc_prio import ikc_pkg::*; (
    input  logic [KW_COUNT-1:0]  i_seen,
    output logic [VERDICT_W-1:0] o_verdict
);

    always_comb begin
        o_verdict = VERDICT_UNKNOWN;
        // lowest set index wins
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (i_seen[k]) begin
                o_verdict = VERDICT_W'(k);
            end
        end
    end

endmodule

>>> src/imap_keyword_classifier.sv
// IMAP keyword classifier: one payload byte per cycle, one verdict per packet.
// Two register stages, the input register and the verdict register: the verdict
// register and o_valid load when the last byte leaves the input register.
// Throughput: one byte per cycle; input stalls only while a last byte waits
// behind an untaken verdict. Reset (synchronous, active low) clears the window, seen
// flags and both valid registers; the window and seen flags clear after each packet.
module imap_keyword_classifier import ikc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [VERDICT_W-1:0] o_verdict
);

`include "assert_macros.svh"

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_last;
    logic                 r_out_valid;
    logic [VERDICT_W-1:0] r_verdict;

    logic                 out_free;
    logic                 consume;
    logic                 in_take;
    t_step                step;
    logic [KW_COUNT-1:0]  seen_next;
    logic [VERDICT_W-1:0] verdict;

    assign out_free = !r_out_valid || !i_stall;
    // only a last byte needs room in the verdict register
    assign consume  = r_in_valid && (!r_in_last || out_free);
    assign o_stall  = r_in_valid && !consume;
    assign in_take  = i_valid && !o_stall;

    assign step.fire = consume;
    assign step.last = r_in_last;
    assign step.data = r_in_byte;

    ikc_match u_match (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .o_seen_next (seen_next)
    );

    ikc_prio u_prio (
        .i_seen    (seen_next),
        .o_verdict (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end
            if (consume && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
        if (consume && r_in_last) begin
            r_verdict <= verdict;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_verdict = r_verdict;

    `ASSERT_IMPLY(a_noop_shadowed, o_valid, o_verdict != VERDICT_NOOP, "NOOP verdict produced")
    `ASSERT_IMPLY(a_verdict_range, o_valid, o_verdict <= VERDICT_UNKNOWN, "verdict out of range")
    `ASSERT_IMPLY(a_stall_cause, o_stall, r_in_last && r_out_valid && i_stall,
        "input stalled without a pending verdict")
    `ASSERT_NEXT(a_last_gives_verdict, consume && r_in_last, o_valid,
        "last byte consumed but no verdict")

endmodule
